### hdl/imap_literal_record_parser_unit_defines.svh
// assertion macros used by the port checker
`ifndef IMAP_LITERAL_RECORD_PARSER_UNIT_DEFINES_SVH
`define IMAP_LITERAL_RECORD_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define ILRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the block clock, off during reset
`define ILRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ilrp_pkg.sv
// shared types, codes and constants of the fetch record literal parser
package ilrp_pkg;

    // default sizes of the parser counters
    localparam int DEPTH_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 16;
    localparam int LEN_BITS_DEF   = 32;

    // result field widths and their saturation limits
    localparam int DROP_W = 16;
    localparam int LIT_W  = 32;
    localparam logic [DROP_W-1:0] DROP_MAX = '1;
    localparam logic [LIT_W-1:0]  LIT_MAX  = '1;

    // result kinds
    localparam logic [1:0] KIND_META      = 2'd0;
    localparam logic [1:0] KIND_LIT_START = 2'd1;
    localparam logic [1:0] KIND_LIT_BYTE  = 2'd2;
    localparam logic [1:0] KIND_END       = 2'd3;

    // literal destinations
    localparam logic [1:0] DEST_DISCARD = 2'd0;
    localparam logic [1:0] DEST_HEADERS = 2'd1;
    localparam logic [1:0] DEST_TEXT    = 2'd2;

    // record end status
    localparam logic STATUS_CLOSED = 1'b0;
    localparam logic STATUS_CUT    = 1'b1;

    // length number phases
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_JUNK   = 2'd3;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // keyword lengths
    localparam logic [2:0] KW_HEADER_LEN = 3'd6;
    localparam logic [2:0] KW_TEXT_LEN   = 3'd4;

    // parser modes
    typedef enum logic [6:0] {
        MODE_IDLE        = 7'b0000001,
        MODE_BODY        = 7'b0000010,
        MODE_NUMBER      = 7'b0000100,
        MODE_AFTER_BRACE = 7'b0001000,
        MODE_AFTER_CR    = 7'b0010000,
        MODE_LITERAL     = 7'b0100000,
        MODE_DONE        = 7'b1000000
    } t_mode;

    // one result word
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        out_byte;
        logic [1:0]        dest;
        logic [DROP_W-1:0] drop_count;
        logic [LIT_W-1:0]  lit_length;
        logic              status;
        logic              final_res;
    } t_result;

    // all words caused by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_pair;

    // "HEADER"
    function automatic logic [7:0] kw_header_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h48;
            3'd1:    return 8'h45;
            3'd2:    return 8'h41;
            3'd3:    return 8'h44;
            3'd4:    return 8'h45;
            3'd5:    return 8'h52;
            default: return 8'h00;
        endcase
    endfunction

    // "TEXT"
    function automatic logic [7:0] kw_text_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h54;
            3'd1:    return 8'h45;
            3'd2:    return 8'h58;
            3'd3:    return 8'h54;
            default: return 8'h00;
        endcase
    endfunction

endpackage

### hdl/ilrp_parser.sv
// parser state and the single-pass step logic for one record byte
module ilrp_parser #(
    parameter int DEPTH_BITS = ilrp_pkg::DEPTH_BITS_DEF,
    parameter int COUNT_BITS = ilrp_pkg::COUNT_BITS_DEF,
    parameter int LEN_BITS   = ilrp_pkg::LEN_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_in_byte,
    input  logic              i_first,
    input  logic              i_last,
    output ilrp_pkg::t_pair   o_pair
);

    localparam int SUMW = COUNT_BITS + 1;
    localparam int DW   = (SUMW > ilrp_pkg::DROP_W + 1) ? SUMW : ilrp_pkg::DROP_W + 1;
    localparam int LW   = (LEN_BITS > ilrp_pkg::LIT_W + 1) ? LEN_BITS : ilrp_pkg::LIT_W + 1;
    localparam int PW   = LEN_BITS + 4;

    function automatic ilrp_pkg::t_result mk(
        input logic [1:0]                  kind,
        input logic [7:0]                  byte_val,
        input logic [1:0]                  dest,
        input logic [ilrp_pkg::DROP_W-1:0] drop,
        input logic [ilrp_pkg::LIT_W-1:0]  len,
        input logic                        status
    );
        ilrp_pkg::t_result r;
        r            = '0;
        r.kind       = kind;
        r.out_byte   = byte_val;
        r.dest       = dest;
        r.drop_count = drop;
        r.lit_length = len;
        r.status     = status;
        return r;
    endfunction

    function automatic ilrp_pkg::t_pair push(input ilrp_pkg::t_pair p,
                                             input ilrp_pkg::t_result r);
        ilrp_pkg::t_pair q;
        q = p;
        if (p.cnt == 2'd0) begin
            q.res0 = r;
        end else begin
            q.res1 = r;
        end
        if (p.cnt != 2'd2) begin
            q.cnt = p.cnt + 2'd1;
        end
        return q;
    endfunction

    ilrp_pkg::t_mode         r_mode,   n_mode;
    logic [DEPTH_BITS-1:0]   r_depth,  n_depth;
    logic [COUNT_BITS-1:0]   r_token,  n_token;
    logic [COUNT_BITS-1:0]   r_space,  n_space;
    logic [2:0]              r_hprog,  n_hprog;
    logic [2:0]              r_tprog,  n_tprog;
    logic                    r_hseen,  n_hseen;
    logic                    r_tseen,  n_tseen;
    logic [1:0]              r_phase,  n_phase;
    logic                    r_neg,    n_neg;
    logic [LEN_BITS-1:0]     r_accum,  n_accum;
    logic [LEN_BITS-1:0]     r_left,   n_left;
    logic [1:0]              r_ldest,  n_ldest;

    ilrp_pkg::t_pair         v_pair;
    logic                    v_body;
    logic                    v_lit;
    logic                    v_meta;
    logic                    v_acc;
    logic                    v_digit;
    logic [LEN_BITS-1:0]     v_len;
    logic [SUMW-1:0]         v_sum;
    logic [DW-1:0]           v_drop_w;
    logic [LW-1:0]           v_len_w;
    logic [1:0]              v_dest;
    logic [PW-1:0]           v_prod;
    logic [7:0]              c;

    assign c = i_in_byte;

    always_comb begin
        n_mode   = r_mode;
        n_depth  = r_depth;
        n_token  = r_token;
        n_space  = r_space;
        n_hprog  = r_hprog;
        n_tprog  = r_tprog;
        n_hseen  = r_hseen;
        n_tseen  = r_tseen;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_accum  = r_accum;
        n_left   = r_left;
        n_ldest  = r_ldest;
        v_pair   = '0;
        v_body   = 1'b0;
        v_lit    = 1'b0;
        v_meta   = 1'b0;
        v_acc    = 1'b0;
        v_len    = '0;
        v_sum    = '0;
        v_drop_w = '0;
        v_len_w  = '0;
        v_dest   = ilrp_pkg::DEST_DISCARD;
        v_prod   = '0;
        v_digit  = c inside {[ilrp_pkg::CH_ZERO:ilrp_pkg::CH_NINE]};

        // first byte after the opening paren restarts the record
        if (i_first) begin
            n_mode  = ilrp_pkg::MODE_BODY;
            n_depth = DEPTH_BITS'(1);
            n_token = '0;
            n_space = '0;
            n_hprog = '0;
            n_tprog = '0;
            n_hseen = 1'b0;
            n_tseen = 1'b0;
            n_phase = ilrp_pkg::PH_LEAD;
            n_neg   = 1'b0;
            n_accum = '0;
            n_left  = '0;
            n_ldest = ilrp_pkg::DEST_DISCARD;
        end

        case (n_mode)
            ilrp_pkg::MODE_BODY: begin
                v_body = 1'b1;
            end
            ilrp_pkg::MODE_NUMBER: begin
                if (c == ilrp_pkg::CH_RBRACE) begin
                    v_len = n_neg ? '0 : n_accum;
                    v_sum = SUMW'(n_token) + SUMW'(n_space);
                    if (v_sum > {1'b0, {COUNT_BITS{1'b1}}}) begin
                        v_sum = {1'b0, {COUNT_BITS{1'b1}}};
                    end
                    v_drop_w = DW'(v_sum);
                    if (v_drop_w > DW'(ilrp_pkg::DROP_MAX)) begin
                        v_drop_w = DW'(ilrp_pkg::DROP_MAX);
                    end
                    v_len_w = LW'(v_len);
                    if (v_len_w > LW'(ilrp_pkg::LIT_MAX)) begin
                        v_len_w = LW'(ilrp_pkg::LIT_MAX);
                    end
                    v_dest = n_hseen ? ilrp_pkg::DEST_HEADERS :
                             (n_tseen ? ilrp_pkg::DEST_TEXT : ilrp_pkg::DEST_DISCARD);
                    v_pair = push(v_pair, mk(ilrp_pkg::KIND_LIT_START, 8'h00, v_dest,
                                             v_drop_w[ilrp_pkg::DROP_W-1:0],
                                             v_len_w[ilrp_pkg::LIT_W-1:0],
                                             ilrp_pkg::STATUS_CLOSED));
                    n_token = '0;
                    n_space = '0;
                    n_hprog = '0;
                    n_tprog = '0;
                    n_hseen = 1'b0;
                    n_tseen = 1'b0;
                    n_ldest = v_dest;
                    n_left  = v_len;
                    n_mode  = ilrp_pkg::MODE_AFTER_BRACE;
                end else begin
                    case (n_phase)
                        ilrp_pkg::PH_LEAD: begin
                            if (c == ilrp_pkg::CH_PLUS) begin
                                n_phase = ilrp_pkg::PH_SIGN;
                            end else if (c == ilrp_pkg::CH_MINUS) begin
                                n_neg   = 1'b1;
                                n_phase = ilrp_pkg::PH_SIGN;
                            end else if (!(c == ilrp_pkg::CH_SPACE ||
                                           c inside {[ilrp_pkg::CH_TAB:ilrp_pkg::CH_CR]})) begin
                                n_phase = v_digit ? ilrp_pkg::PH_DIGITS : ilrp_pkg::PH_JUNK;
                                v_acc   = v_digit;
                            end
                        end
                        ilrp_pkg::PH_SIGN: begin
                            n_phase = v_digit ? ilrp_pkg::PH_DIGITS : ilrp_pkg::PH_JUNK;
                            v_acc   = v_digit;
                        end
                        ilrp_pkg::PH_DIGITS: begin
                            if (!v_digit) begin
                                n_phase = ilrp_pkg::PH_JUNK;
                            end
                            v_acc = v_digit;
                        end
                        default: begin
                        end
                    endcase
                    // accum * 10 + digit, saturating
                    if (v_acc) begin
                        v_prod = (PW'(n_accum) << 3) + (PW'(n_accum) << 1) + PW'(c[3:0]);
                        if (v_prod > PW'({LEN_BITS{1'b1}})) begin
                            n_accum = '1;
                        end else begin
                            n_accum = v_prod[LEN_BITS-1:0];
                        end
                    end
                end
            end
            ilrp_pkg::MODE_AFTER_BRACE: begin
                if (c == ilrp_pkg::CH_CR) begin
                    n_mode = ilrp_pkg::MODE_AFTER_CR;
                end else if (c == ilrp_pkg::CH_LF) begin
                    n_mode = (n_left != '0) ? ilrp_pkg::MODE_LITERAL : ilrp_pkg::MODE_BODY;
                end else if (n_left != '0) begin
                    n_mode = ilrp_pkg::MODE_LITERAL;
                    v_lit  = 1'b1;
                end else begin
                    n_mode = ilrp_pkg::MODE_BODY;
                    v_body = 1'b1;
                end
            end
            ilrp_pkg::MODE_AFTER_CR: begin
                if (c == ilrp_pkg::CH_LF) begin
                    n_mode = (n_left != '0) ? ilrp_pkg::MODE_LITERAL : ilrp_pkg::MODE_BODY;
                end else if (n_left != '0) begin
                    n_mode = ilrp_pkg::MODE_LITERAL;
                    v_lit  = 1'b1;
                end else begin
                    n_mode = ilrp_pkg::MODE_BODY;
                    v_body = 1'b1;
                end
            end
            ilrp_pkg::MODE_LITERAL: begin
                v_lit = 1'b1;
            end
            default: begin
            end
        endcase

        // literal payload byte
        if (v_lit) begin
            v_pair = push(v_pair, mk(ilrp_pkg::KIND_LIT_BYTE, c, n_ldest, '0, '0,
                                     ilrp_pkg::STATUS_CLOSED));
            if (n_left != '0) begin
                n_left = n_left - LEN_BITS'(1);
            end
            if (n_left == '0) begin
                n_mode = ilrp_pkg::MODE_BODY;
            end
        end

        // ordinary record byte: parens, brace or metadata
        if (v_body) begin
            if (c == ilrp_pkg::CH_LPAREN) begin
                if (n_depth != '1) begin
                    n_depth = n_depth + DEPTH_BITS'(1);
                end
                v_meta = 1'b1;
            end else if (c == ilrp_pkg::CH_RPAREN) begin
                if (n_depth != '0) begin
                    n_depth = n_depth - DEPTH_BITS'(1);
                end
                if (n_depth != '0) begin
                    v_meta = 1'b1;
                end else begin
                    v_pair = push(v_pair, mk(ilrp_pkg::KIND_END, 8'h00, ilrp_pkg::DEST_DISCARD,
                                             '0, '0, ilrp_pkg::STATUS_CLOSED));
                    n_mode = ilrp_pkg::MODE_DONE;
                end
            end else if (c == ilrp_pkg::CH_LBRACE) begin
                n_mode  = ilrp_pkg::MODE_NUMBER;
                n_phase = ilrp_pkg::PH_LEAD;
                n_neg   = 1'b0;
                n_accum = '0;
            end else begin
                v_meta = 1'b1;
            end
        end

        // metadata byte: keyword and space tracking
        if (v_meta) begin
            v_pair = push(v_pair, mk(ilrp_pkg::KIND_META, c, ilrp_pkg::DEST_DISCARD, '0, '0,
                                     ilrp_pkg::STATUS_CLOSED));
            if (c == ilrp_pkg::CH_SPACE) begin
                if (n_space != '1) begin
                    n_space = n_space + COUNT_BITS'(1);
                end
            end else begin
                // a new token after spaces starts a fresh keyword
                if (n_space != '0) begin
                    n_token = '0;
                    n_space = '0;
                    n_hprog = '0;
                    n_tprog = '0;
                    n_hseen = 1'b0;
                    n_tseen = 1'b0;
                end
                if (n_token != '1) begin
                    n_token = n_token + COUNT_BITS'(1);
                end
                if (!n_hseen) begin
                    if (n_hprog < ilrp_pkg::KW_HEADER_LEN &&
                        c == ilrp_pkg::kw_header_char(n_hprog)) begin
                        n_hprog = n_hprog + 3'd1;
                        if (n_hprog == ilrp_pkg::KW_HEADER_LEN) begin
                            n_hseen = 1'b1;
                            n_hprog = '0;
                        end
                    end else begin
                        n_hprog = (c == ilrp_pkg::CH_H) ? 3'd1 : 3'd0;
                    end
                end
                if (!n_tseen) begin
                    if (n_tprog < ilrp_pkg::KW_TEXT_LEN &&
                        c == ilrp_pkg::kw_text_char(n_tprog)) begin
                        n_tprog = n_tprog + 3'd1;
                        if (n_tprog == ilrp_pkg::KW_TEXT_LEN) begin
                            n_tseen = 1'b1;
                            n_tprog = '0;
                        end
                    end else begin
                        n_tprog = (c == ilrp_pkg::CH_T) ? 3'd1 : 3'd0;
                    end
                end
            end
        end

        // raw buffer ran out before the record closed
        if (i_last && n_mode != ilrp_pkg::MODE_IDLE && n_mode != ilrp_pkg::MODE_DONE) begin
            v_pair = push(v_pair, mk(ilrp_pkg::KIND_END, 8'h00, ilrp_pkg::DEST_DISCARD,
                                     '0, '0, ilrp_pkg::STATUS_CUT));
            n_mode = ilrp_pkg::MODE_DONE;
        end

        if (v_pair.cnt == 2'd1) begin
            v_pair.res0.final_res = 1'b1;
        end else if (v_pair.cnt == 2'd2) begin
            v_pair.res1.final_res = 1'b1;
        end
    end

    assign o_pair = v_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ilrp_pkg::MODE_IDLE;
            r_depth <= '0;
            r_token <= '0;
            r_space <= '0;
            r_hprog <= '0;
            r_tprog <= '0;
            r_hseen <= 1'b0;
            r_tseen <= 1'b0;
            r_phase <= ilrp_pkg::PH_LEAD;
            r_neg   <= 1'b0;
            r_accum <= '0;
            r_left  <= '0;
            r_ldest <= ilrp_pkg::DEST_DISCARD;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_token <= n_token;
            r_space <= n_space;
            r_hprog <= n_hprog;
            r_tprog <= n_tprog;
            r_hseen <= n_hseen;
            r_tseen <= n_tseen;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_ldest <= n_ldest;
        end
    end

endmodule

### hdl/imap_literal_record_parser_unit.sv
// top level of the fetch record literal parser: input register, step logic, result buffer
//
// takes one record byte per cycle while o_in_stall is low (the byte after the opening
// paren first, flagged by i_first) and gives metadata bytes, literal-start words with
// drop count, destination and length, literal bytes, and a record-end word with closed
// or cut-off status. a byte that causes one word or none is taken every cycle while the
// output is not stalled; a byte that causes two words (a literal start, data or metadata
// byte followed by a cut-off end) holds the buffer until both have left, since the port
// moves one word per cycle when not stalled. a word passes the input register and the
// result buffer before it reaches the port. o_final_res marks the last word of each
// input byte. all per-byte work is one pass of combinational logic between the input
// register and the two-word result buffer; the length parse is a shift-add per digit.
module imap_literal_record_parser_unit #(
    parameter int DEPTH_BITS = ilrp_pkg::DEPTH_BITS_DEF,
    parameter int COUNT_BITS = ilrp_pkg::COUNT_BITS_DEF,
    parameter int LEN_BITS   = ilrp_pkg::LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_first,
    input  logic        i_last,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_dest,
    output logic [15:0] o_drop_count,
    output logic [31:0] o_lit_length,
    output logic        o_status,
    output logic        o_final_res
);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_first;
    logic              r_in_last;

    // result buffer: up to two words from one input byte, slot 0 is on the port
    logic [1:0]        r_cnt;
    ilrp_pkg::t_result r_slot0;
    ilrp_pkg::t_result r_slot1;

    ilrp_pkg::t_pair   w_pair;
    logic              w_take;
    logic              w_can_load;
    logic              w_step;
    logic              w_in_ready;
    logic              w_in_accept;

    // output word leaves this cycle
    assign w_take      = (r_cnt != 2'd0) && !i_out_stall;
    // buffer is free next cycle: empty, or its last word leaves now
    assign w_can_load  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_take);
    // the registered byte is processed and its words land in the buffer
    assign w_step      = r_in_valid && w_can_load;
    // input register takes a new byte when empty or moving on this cycle
    assign w_in_ready  = !r_in_valid || w_can_load;
    assign w_in_accept = i_in_valid && w_in_ready;
    assign o_in_stall  = !w_in_ready;

    ilrp_parser #(
        .DEPTH_BITS (DEPTH_BITS),
        .COUNT_BITS (COUNT_BITS),
        .LEN_BITS   (LEN_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_in_byte (r_in_byte),
        .i_first   (r_in_first),
        .i_last    (r_in_last),
        .o_pair    (w_pair)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_cnt <= w_pair.cnt;
            end else if (w_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte  <= i_in_byte;
            r_in_first <= i_first;
            r_in_last  <= i_last;
        end
        if (w_step) begin
            r_slot0 <= w_pair.res0;
            r_slot1 <= w_pair.res1;
        end else if (w_take && (r_cnt == 2'd2)) begin
            // second word moves up to the port
            r_slot0 <= r_slot1;
        end
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_kind       = r_slot0.kind;
    assign o_out_byte   = r_slot0.out_byte;
    assign o_dest       = r_slot0.dest;
    assign o_drop_count = r_slot0.drop_count;
    assign o_lit_length = r_slot0.lit_length;
    assign o_status     = r_slot0.status;
    assign o_final_res  = r_slot0.final_res;

endmodule

### hdl/ilrp_check.sv
// port checker for the fetch record literal parser, bound to the top level
`include "imap_literal_record_parser_unit_defines.svh"

module ilrp_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_byte,
    input logic        i_first,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_dest,
    input logic [15:0] o_drop_count,
    input logic [31:0] o_lit_length,
    input logic        o_status,
    input logic        o_final_res
);

    // a stalled word stays on the port unchanged
    `ILRP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_out_byte) && $stable(o_lit_length) && $stable(o_final_res), "stalled result word changed")

    // a record end is always the last word of its input byte
    `ILRP_ASSERT_NOW(a_end_final, o_out_valid && o_kind == ilrp_pkg::KIND_END, o_final_res, "record end word not marked final")

    // drop count and length only travel with a literal start
    `ILRP_ASSERT_NOW(a_start_only, o_out_valid && o_kind != ilrp_pkg::KIND_LIT_START, o_lit_length == 32'd0 && o_drop_count == 16'd0, "length or drop count outside literal start")

    // status only on record end, destination never out of range
    `ILRP_ASSERT_NOW(a_status_dest, o_out_valid && o_kind != ilrp_pkg::KIND_END, !o_status && o_dest != 2'd3, "bad status or destination")

endmodule

bind imap_literal_record_parser_unit ilrp_check u_ilrp_check (.*);
